// ===== src/yoyo_position_controller_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the yoyo position controller
// Short forms of the concurrent checks, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef YOYO_POSITION_CONTROLLER_TOP_MACROS_SVH
`define YOYO_POSITION_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication
`define YPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define YPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/yoyo_pc_pkg.sv =====
// ----------------------------------------------------------------------------
// yoyo_pc_pkg
// Widths, phase codes, register indexes and shared types of the controller.
// ----------------------------------------------------------------------------
package yoyo_pc_pkg;

    localparam int POS_W      = 32;
    localparam int ERR_W      = POS_W + 1;
    localparam int CNT_W      = 16;
    localparam int TOL_W      = 20;
    localparam int GAIN_W     = 24;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = POS_W + GAIN_W;
    localparam int MAG_W      = PROD_W - FRAC_BITS;
    localparam int SPD_W      = 12;
    localparam int CMD_W      = SPD_W + 1;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
    localparam logic [PHASE_W-1:0] PH_MOVE_LOW   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DWELL_LOW  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_MOVE_HIGH  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DWELL_HIGH = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_COUNT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS = 3'd7;

    localparam logic [SPD_W-1:0] SPEED_MIN_RST = 12'd1400;
    localparam logic [SPD_W-1:0] SPEED_MAX_RST = 12'd3200;

    typedef struct packed {
        logic [POS_W-1:0]  target_low;
        logic [POS_W-1:0]  target_high;
        logic [TOL_W-1:0]  tolerance;
        logic [GAIN_W-1:0] gain;
        logic [SPD_W-1:0]  speed_min;
        logic [SPD_W-1:0]  speed_max;
        logic [CNT_W-1:0]  cycle_count;
        logic [CNT_W-1:0]  dwell_ticks;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               sample_valid;
        logic               test_done;
    } status_t;

endpackage

// ===== src/yoyo_pc_in_if.sv =====
// ----------------------------------------------------------------------------
// yoyo_pc_in_if
// Input channel: start or tick beats with encoder count and abort.
// ----------------------------------------------------------------------------
interface yoyo_pc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic signed [yoyo_pc_pkg::POS_W-1:0] encoder_count;
    logic                                abort;

    modport source (output valid, operation, encoder_count, abort, input ready);
    modport sink   (input valid, operation, encoder_count, abort, output ready);
endinterface

// ===== src/yoyo_pc_out_if.sv =====
// ----------------------------------------------------------------------------
// yoyo_pc_out_if
// Result channel: speed command and test status per beat.
// ----------------------------------------------------------------------------
interface yoyo_pc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [yoyo_pc_pkg::CMD_W-1:0]   speed_command;
    logic [yoyo_pc_pkg::PHASE_W-1:0]        phase;
    logic                                  sample_valid;
    logic                                  test_done;

    modport source (output valid, speed_command, phase, sample_valid, test_done,
                    input ready);
    modport sink   (input valid, speed_command, phase, sample_valid, test_done,
                    output ready);
endinterface

// ===== src/yoyo_pc_ctrl.sv =====
// ----------------------------------------------------------------------------
// yoyo_pc_ctrl
// Test sequencer: phase, cycle and dwell counters, move-complete decision.
// ----------------------------------------------------------------------------
module yoyo_pc_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step,
    input  logic                                 op_start,
    input  logic                                 op_abort,
    input  logic [yoyo_pc_pkg::ERR_W-1:0]        err_low,
    input  logic [yoyo_pc_pkg::ERR_W-1:0]        err_high,
    input  yoyo_pc_pkg::cfg_t                    cfg,
    output yoyo_pc_pkg::status_t                 status_reg,
    output logic                                 drive_reg,
    output logic [yoyo_pc_pkg::ERR_W-1:0]        err_reg
);

    logic [yoyo_pc_pkg::PHASE_W-1:0] phase_reg, phase_next, phase_cur;
    logic [yoyo_pc_pkg::CNT_W-1:0]   cycles_reg, cycles_next, cycles_dec;
    logic [yoyo_pc_pkg::CNT_W-1:0]   dwell_reg, dwell_next, dwell_dec;
    logic [yoyo_pc_pkg::ERR_W-1:0]   err_sel, neg_tol;
    logic                            side_high, near, after_dwell;
    logic                            sample_valid, test_done, drive;

    assign phase_cur  = (phase_reg > yoyo_pc_pkg::PH_DWELL_HIGH) ? yoyo_pc_pkg::PH_IDLE
                                                                  : phase_reg;
    assign side_high  = (phase_cur == yoyo_pc_pkg::PH_MOVE_HIGH) ||
                        (phase_cur == yoyo_pc_pkg::PH_DWELL_HIGH);
    assign err_sel    = side_high ? err_high : err_low;
    assign neg_tol    = yoyo_pc_pkg::ERR_W'(0) - yoyo_pc_pkg::ERR_W'(cfg.tolerance);
    assign cycles_dec = cycles_reg - yoyo_pc_pkg::CNT_W'(1);
    assign dwell_dec  = dwell_reg - yoyo_pc_pkg::CNT_W'(1);

    // |err| < tol without taking the magnitude first
    assign near = err_sel[yoyo_pc_pkg::ERR_W-1]
                ? ($signed(err_sel) > $signed(neg_tol))
                : (err_sel < yoyo_pc_pkg::ERR_W'(cfg.tolerance));

    always_comb
    begin
        phase_next   = phase_cur;
        cycles_next  = cycles_reg;
        dwell_next   = dwell_reg;
        sample_valid = 1'b0;
        test_done    = 1'b0;
        drive        = 1'b0;
        after_dwell  = 1'b0;
        if (op_abort)
        begin
            test_done   = (phase_cur != yoyo_pc_pkg::PH_IDLE);
            phase_next  = yoyo_pc_pkg::PH_IDLE;
            cycles_next = '0;
            dwell_next  = '0;
        end
        else if (op_start)
        begin
            cycles_next = cfg.cycle_count;
            dwell_next  = '0;
            if (cfg.cycle_count == '0)
            begin
                phase_next = yoyo_pc_pkg::PH_IDLE;
                test_done  = 1'b1;
            end
            else
            begin
                phase_next = yoyo_pc_pkg::PH_MOVE_LOW;
            end
        end
        else
        begin
            case (phase_cur)
                yoyo_pc_pkg::PH_MOVE_LOW, yoyo_pc_pkg::PH_MOVE_HIGH:
                begin
                    sample_valid = 1'b1;
                    if (!near)
                    begin
                        drive = 1'b1;
                    end
                    else
                    begin
                        dwell_next = cfg.dwell_ticks;
                        if (cfg.dwell_ticks == '0)
                            after_dwell = 1'b1;
                        else
                            phase_next = side_high ? yoyo_pc_pkg::PH_DWELL_HIGH
                                                   : yoyo_pc_pkg::PH_DWELL_LOW;
                    end
                end
                yoyo_pc_pkg::PH_DWELL_LOW, yoyo_pc_pkg::PH_DWELL_HIGH:
                begin
                    sample_valid = 1'b1;
                    dwell_next   = dwell_dec;
                    if (dwell_dec == '0)
                        after_dwell = 1'b1;
                end
                default:
                begin
                    phase_next = yoyo_pc_pkg::PH_IDLE;
                end
            endcase

            // leave the dwell: go up, or count one cycle and maybe finish
            if (after_dwell)
            begin
                if (!side_high)
                begin
                    phase_next = yoyo_pc_pkg::PH_MOVE_HIGH;
                end
                else
                begin
                    cycles_next = cycles_dec;
                    if (cycles_dec == '0)
                    begin
                        phase_next = yoyo_pc_pkg::PH_IDLE;
                        test_done  = 1'b1;
                    end
                    else
                    begin
                        phase_next = yoyo_pc_pkg::PH_MOVE_LOW;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= yoyo_pc_pkg::PH_IDLE;
            cycles_reg <= '0;
            dwell_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            cycles_reg <= cycles_next;
            dwell_reg  <= dwell_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            status_reg.phase        <= phase_next;
            status_reg.sample_valid <= sample_valid;
            status_reg.test_done    <= test_done;
            drive_reg               <= drive;
            err_reg                 <= err_sel;
        end
    end

endmodule

// ===== src/yoyo_pc_drive.sv =====
// ----------------------------------------------------------------------------
// yoyo_pc_drive
// Drive path: error magnitude, gain multiply, clamp and sign of the command.
// ----------------------------------------------------------------------------
module yoyo_pc_drive (
    input  logic                                  clk,
    input  logic                                  en_abs,
    input  logic                                  en_mul,
    input  logic                                  en_out,
    input  yoyo_pc_pkg::status_t                  status_in,
    input  logic                                  drive_in,
    input  logic [yoyo_pc_pkg::ERR_W-1:0]         err_in,
    input  yoyo_pc_pkg::cfg_t                     cfg,
    output yoyo_pc_pkg::status_t                  status_reg,
    output logic signed [yoyo_pc_pkg::CMD_W-1:0]  cmd_reg
);

    // magnitude stage
    yoyo_pc_pkg::status_t              abs_status_reg;
    logic                              abs_drive_reg, abs_neg_reg;
    logic [yoyo_pc_pkg::POS_W-1:0]     abs_err_reg;
    logic [yoyo_pc_pkg::ERR_W-1:0]     err_negated;
    logic [yoyo_pc_pkg::POS_W-1:0]     err_abs;

    // multiply stage
    yoyo_pc_pkg::status_t              mul_status_reg;
    logic                              mul_neg_reg;
    logic [yoyo_pc_pkg::MAG_W-1:0]     mul_mag_reg;
    logic [yoyo_pc_pkg::PROD_W-1:0]    product;

    // clamp
    logic [yoyo_pc_pkg::SPD_W-1:0]     mag_sat;
    logic [yoyo_pc_pkg::CMD_W-1:0]     mag_ext;

    assign err_negated = yoyo_pc_pkg::ERR_W'(0) - err_in;
    assign err_abs     = err_in[yoyo_pc_pkg::ERR_W-1] ? err_negated[yoyo_pc_pkg::POS_W-1:0]
                                                      : err_in[yoyo_pc_pkg::POS_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en_abs)
        begin
            abs_status_reg <= status_in;
            abs_drive_reg  <= drive_in;
            abs_neg_reg    <= drive_in & err_in[yoyo_pc_pkg::ERR_W-1];
            abs_err_reg    <= err_abs;
        end
    end

    assign product = yoyo_pc_pkg::PROD_W'(abs_err_reg) * yoyo_pc_pkg::PROD_W'(cfg.gain);

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            mul_status_reg <= abs_status_reg;
            mul_neg_reg    <= abs_neg_reg;
            mul_mag_reg    <= abs_drive_reg ? product[yoyo_pc_pkg::PROD_W-1:yoyo_pc_pkg::FRAC_BITS]
                                            : '0;
        end
    end

    // saturate first, then lift a small nonzero drive to the minimum
    always_comb
    begin
        if (mul_mag_reg > yoyo_pc_pkg::MAG_W'(cfg.speed_max))
            mag_sat = cfg.speed_max;
        else if ((mul_mag_reg != '0) &&
                 (mul_mag_reg < yoyo_pc_pkg::MAG_W'(cfg.speed_min)))
            mag_sat = cfg.speed_min;
        else
            mag_sat = mul_mag_reg[yoyo_pc_pkg::SPD_W-1:0];
    end

    assign mag_ext = {1'b0, mag_sat};

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            status_reg <= mul_status_reg;
            cmd_reg    <= mul_neg_reg ? $signed(yoyo_pc_pkg::CMD_W'(0) - mag_ext)
                                      : $signed(mag_ext);
        end
    end

endmodule

// ===== src/yoyo_position_controller_top.sv =====
// ----------------------------------------------------------------------------
// yoyo_position_controller_top
// Cyclic low/high position test with a saturated proportional drive.
//
//   channel | dir | beat contents
//   --------+-----+---------------------------------------------------
//   req     | in  | operation, encoder_count, abort
//   rsp     | out | speed_command, phase, sample_valid, test_done
//   cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One beat per cycle sustained while rsp is ready; a beat is registered in the
// error register at the edge that takes it, then in sequencer, magnitude,
// multiply and output. The sequencer updates phase and counters once per beat.
// Each stage holds under back-pressure and moves up into an empty slot, so
// req stays ready while bubbles remain. Reset is asynchronous, active low;
// the test is idle; only config, valid bits and sequencer state are reset.
// ----------------------------------------------------------------------------
`include "yoyo_position_controller_top_macros.svh"

module yoyo_position_controller_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [yoyo_pc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [yoyo_pc_pkg::CFG_DATA_W-1:0]     cfg_data,
    yoyo_pc_in_if.sink                             req,
    yoyo_pc_out_if.source                          rsp
);

    yoyo_pc_pkg::cfg_t                 cfg_reg;

    // stage valid bits: input, sequencer, magnitude, multiply, output
    logic                              in_vld_reg, seq_vld_reg, abs_vld_reg;
    logic                              mul_vld_reg, out_vld_reg;
    logic                              adv_in, adv_seq, adv_abs, adv_mul, adv_out;

    logic                              in_start_reg, in_abort_reg;
    logic [yoyo_pc_pkg::ERR_W-1:0]     in_err_low_reg, in_err_high_reg;

    yoyo_pc_pkg::status_t              seq_status, out_status;
    logic                              seq_drive;
    logic [yoyo_pc_pkg::ERR_W-1:0]     seq_err;
    logic signed [yoyo_pc_pkg::CMD_W-1:0] out_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_low  <= '0;
            cfg_reg.target_high <= '0;
            cfg_reg.tolerance   <= '0;
            cfg_reg.gain        <= '0;
            cfg_reg.speed_min   <= yoyo_pc_pkg::SPEED_MIN_RST;
            cfg_reg.speed_max   <= yoyo_pc_pkg::SPEED_MAX_RST;
            cfg_reg.cycle_count <= '0;
            cfg_reg.dwell_ticks <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                yoyo_pc_pkg::CFG_TARGET_LOW:
                    cfg_reg.target_low  <= cfg_data[yoyo_pc_pkg::POS_W-1:0];
                yoyo_pc_pkg::CFG_TARGET_HIGH:
                    cfg_reg.target_high <= cfg_data[yoyo_pc_pkg::POS_W-1:0];
                yoyo_pc_pkg::CFG_TOLERANCE:
                    cfg_reg.tolerance   <= cfg_data[yoyo_pc_pkg::TOL_W-1:0];
                yoyo_pc_pkg::CFG_GAIN:
                    cfg_reg.gain        <= cfg_data[yoyo_pc_pkg::GAIN_W-1:0];
                yoyo_pc_pkg::CFG_SPEED_MIN:
                    cfg_reg.speed_min   <= cfg_data[yoyo_pc_pkg::SPD_W-1:0];
                yoyo_pc_pkg::CFG_SPEED_MAX:
                    cfg_reg.speed_max   <= cfg_data[yoyo_pc_pkg::SPD_W-1:0];
                yoyo_pc_pkg::CFG_CYCLE_COUNT:
                    cfg_reg.cycle_count <= cfg_data[yoyo_pc_pkg::CNT_W-1:0];
                yoyo_pc_pkg::CFG_DWELL_TICKS:
                    cfg_reg.dwell_ticks <= cfg_data[yoyo_pc_pkg::CNT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // a stage advances when it is empty or its successor advances
    assign adv_out   = !out_vld_reg || rsp.ready;
    assign adv_mul   = !mul_vld_reg || adv_out;
    assign adv_abs   = !abs_vld_reg || adv_mul;
    assign adv_seq   = !seq_vld_reg || adv_abs;
    assign adv_in    = !in_vld_reg  || adv_seq;
    assign req.ready = adv_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            seq_vld_reg <= 1'b0;
            abs_vld_reg <= 1'b0;
            mul_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv_in)
                in_vld_reg  <= req.valid;
            if (adv_seq)
                seq_vld_reg <= in_vld_reg;
            if (adv_abs)
                abs_vld_reg <= seq_vld_reg;
            if (adv_mul)
                mul_vld_reg <= abs_vld_reg;
            if (adv_out)
                out_vld_reg <= mul_vld_reg;
        end
    end

    // errors against both targets; the sequencer picks one by phase
    always_ff @(posedge clk)
    begin
        if (adv_in && req.valid)
        begin
            in_start_reg    <= req.operation;
            in_abort_reg    <= req.abort;
            in_err_low_reg  <= {cfg_reg.target_low[yoyo_pc_pkg::POS_W-1], cfg_reg.target_low}
                             - {req.encoder_count[yoyo_pc_pkg::POS_W-1], req.encoder_count};
            in_err_high_reg <= {cfg_reg.target_high[yoyo_pc_pkg::POS_W-1], cfg_reg.target_high}
                             - {req.encoder_count[yoyo_pc_pkg::POS_W-1], req.encoder_count};
        end
    end

    yoyo_pc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (adv_seq && in_vld_reg),
        .op_start   (in_start_reg),
        .op_abort   (in_abort_reg),
        .err_low    (in_err_low_reg),
        .err_high   (in_err_high_reg),
        .cfg        (cfg_reg),
        .status_reg (seq_status),
        .drive_reg  (seq_drive),
        .err_reg    (seq_err)
    );

    yoyo_pc_drive u_drive (
        .clk        (clk),
        .en_abs     (adv_abs && seq_vld_reg),
        .en_mul     (adv_mul && abs_vld_reg),
        .en_out     (adv_out && mul_vld_reg),
        .status_in  (seq_status),
        .drive_in   (seq_drive),
        .err_in     (seq_err),
        .cfg        (cfg_reg),
        .status_reg (out_status),
        .cmd_reg    (out_cmd)
    );

    assign rsp.valid         = out_vld_reg;
    assign rsp.speed_command = out_cmd;
    assign rsp.phase         = out_status.phase;
    assign rsp.sample_valid  = out_status.sample_valid;
    assign rsp.test_done     = out_status.test_done;

    `YPC_ASSERT_SAME(a_done_is_idle, rsp.valid && rsp.test_done, rsp.phase == yoyo_pc_pkg::PH_IDLE, "test_done with a phase other than idle")
    `YPC_ASSERT_SAME(a_drive_in_move, rsp.valid && (rsp.speed_command != '0), rsp.sample_valid && (rsp.phase == yoyo_pc_pkg::PH_MOVE_LOW || rsp.phase == yoyo_pc_pkg::PH_MOVE_HIGH), "nonzero drive outside a move")
    `YPC_ASSERT_NEXT(a_input_held, in_vld_reg && !adv_seq, in_vld_reg, "input stage lost a beat while stalled")

endmodule

// ===== test/yoyo_position_controller_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yoyo_position_controller_top_tb
// Self-checking bench for the cyclic low/high position controller. A local
// predictor tracks the test sequencer and the saturated proportional drive
// for every beat taken on req. Each rsp beat is compared in order against
// the predicted status. Directed beats cover register extremes and drive
// shaping; random runs follow whole test cycles, most under random back-pressure.
// ----------------------------------------------------------------------------
module yoyo_position_controller_top_tb;
    import yoyo_pc_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0]   speed_command;
        logic [PHASE_W-1:0] phase;
        logic               sample_valid;
        logic               test_done;
    } drive_status_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    yoyo_pc_in_if  req_if ();
    yoyo_pc_out_if rsp_if ();

    yoyo_position_controller_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    // Shadow of the register file and of the sequencer state
    cfg_t             settings;
    logic [PHASE_W-1:0] seq_phase;
    logic [CNT_W-1:0] cycles_left;
    logic [CNT_W-1:0] dwell_left;

    drive_status_t pending_status_q[$];
    drive_status_t want_status;
    drive_status_t seen_status;

    int  beats_sent;
    int  results_seen;
    int  mismatches;
    int  tests_ended;
    int  moves_done;
    int  drives_limited;
    int  hold_cycles;
    bit  src_gaps;
    bit  sink_gaps;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("timeout with %0d results outstanding", pending_status_q.size());
        $display("FAIL yoyo_position_controller_top");
        $finish;
    end

    // Leave a dwell; returns 1 when the last cycle of the test is done
    function automatic bit close_dwell(input logic [PHASE_W-1:0] dwell_phase);
        if (dwell_phase == PH_DWELL_LOW)
        begin
            seq_phase = PH_MOVE_HIGH;
            return 1'b0;
        end
        cycles_left = cycles_left - 1'b1;
        if (cycles_left == '0)
        begin
            seq_phase = PH_IDLE;
            return 1'b1;
        end
        seq_phase = PH_MOVE_LOW;
        return 1'b0;
    endfunction

    function automatic drive_status_t advance_sequencer(input logic op,
                                                        input logic signed [POS_W-1:0] enc,
                                                        input logic stop);
        drive_status_t      r;
        longint             aim;
        longint             err;
        longint unsigned    aerr;
        longint unsigned    mag;
        logic [CMD_W-1:0]   m13;
        logic [PHASE_W-1:0] next_dwell;
        bit                 neg;
        r = '0;
        neg = 1'b0;
        mag = 0;
        if (seq_phase > PH_DWELL_HIGH)
            seq_phase = PH_IDLE;
        if (stop)
        begin
            r.test_done = (seq_phase != PH_IDLE);
            seq_phase = PH_IDLE;
            cycles_left = '0;
            dwell_left = '0;
        end
        else if (op)
        begin
            cycles_left = settings.cycle_count;
            dwell_left = '0;
            if (cycles_left == '0)
            begin
                seq_phase = PH_IDLE;
                r.test_done = 1'b1;
            end
            else
                seq_phase = PH_MOVE_LOW;
        end
        else if (seq_phase == PH_MOVE_LOW || seq_phase == PH_MOVE_HIGH)
        begin
            aim = (seq_phase == PH_MOVE_LOW) ? longint'($signed(settings.target_low))
                                             : longint'($signed(settings.target_high));
            err = aim - longint'(enc);
            aerr = (err < 0) ? longint'(-err) : err;
            r.sample_valid = 1'b1;
            if (aerr >= settings.tolerance)
            begin
                neg = (err < 0);
                mag = (aerr * settings.gain) >> FRAC_BITS;
                if (mag > settings.speed_max)
                begin
                    mag = settings.speed_max;
                    drives_limited++;
                end
                else if (mag > 0 && mag < settings.speed_min)
                begin
                    mag = settings.speed_min;
                    drives_limited++;
                end
            end
            else
            begin
                moves_done++;
                next_dwell = (seq_phase == PH_MOVE_LOW) ? PH_DWELL_LOW : PH_DWELL_HIGH;
                dwell_left = settings.dwell_ticks;
                if (dwell_left == '0)
                    r.test_done = close_dwell(next_dwell);
                else
                    seq_phase = next_dwell;
            end
        end
        else if (seq_phase == PH_DWELL_LOW || seq_phase == PH_DWELL_HIGH)
        begin
            r.sample_valid = 1'b1;
            dwell_left = dwell_left - 1'b1;
            if (dwell_left == '0)
                r.test_done = close_dwell(seq_phase);
        end
        m13 = mag[CMD_W-1:0];
        r.speed_command = neg ? -m13 : m13;
        r.phase = seq_phase;
        if (r.test_done)
            tests_ended++;
        return r;
    endfunction

    task automatic send_beat(input logic op, input logic [POS_W-1:0] enc, input logic stop);
        drive_status_t want;
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.operation     <= op;
        req_if.encoder_count <= enc;
        req_if.abort         <= stop;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        want = advance_sequencer(op, enc, stop);
        pending_status_q.push_back(want);
        beats_sent++;
    endtask

    // Always waits on the clock before checking, so valid is never dropped and raised in one step
    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_status_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t s);
        write_reg(CFG_TARGET_LOW, s.target_low);
        write_reg(CFG_TARGET_HIGH, s.target_high);
        write_reg(CFG_TOLERANCE, 32'(s.tolerance));
        write_reg(CFG_GAIN, 32'(s.gain));
        write_reg(CFG_SPEED_MIN, 32'(s.speed_min));
        write_reg(CFG_SPEED_MAX, 32'(s.speed_max));
        write_reg(CFG_CYCLE_COUNT, 32'(s.cycle_count));
        write_reg(CFG_DWELL_TICKS, 32'(s.dwell_ticks));
        cfg_we <= 1'b0;
        settings = s;
    endtask

    function automatic logic [POS_W-1:0] pick_target();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom();
            default: return 32'(int'($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    function automatic cfg_t make_settings(input bit zero_tol);
        cfg_t s;
        s.target_low  = pick_target();
        s.target_high = pick_target();
        if (zero_tol)
            s.tolerance = '0;
        else if ($urandom_range(0, 9) == 0)
            s.tolerance = '1;
        else
            s.tolerance = TOL_W'($urandom_range(1, 2000));
        case ($urandom_range(0, 9))
            0: s.gain = '0;
            1, 2, 3: s.gain = GAIN_W'($urandom());
            default: s.gain = GAIN_W'($urandom_range(0, 1 << 18));
        endcase
        s.speed_min   = SPD_W'($urandom_range(0, 3200));
        s.speed_max   = SPD_W'($urandom_range(0, 3200));
        s.cycle_count = ($urandom_range(0, 9) == 0) ? '0 : CNT_W'($urandom_range(1, 3));
        s.dwell_ticks = CNT_W'($urandom_range(0, 4));
        return s;
    endfunction

    // Mostly aim the encoder at or near the active target so moves finish
    task automatic random_beat();
        logic             op;
        logic             stop;
        logic [POS_W-1:0] aim;
        int               band;
        int               off;
        int unsigned      roll;
        roll = $urandom_range(0, 99);
        aim = (seq_phase == PH_MOVE_HIGH || seq_phase == PH_DWELL_HIGH) ? settings.target_high
                                                                        : settings.target_low;
        stop = (roll == 0);
        op = (seq_phase == PH_IDLE) ? (roll < 70) : (roll >= 97);
        band = int'(settings.tolerance);
        roll = $urandom_range(0, 9);
        if (roll < 5 && band > 0)
        begin
            off = int'($urandom_range(0, band - 1));
            if ($urandom_range(0, 1))
                off = -off;
        end
        else if (roll < 8)
            off = int'($urandom_range(0, 2 * band + 8000)) - band - 4000;
        else
            off = int'($urandom());
        send_beat(op, aim + off, stop);
    endtask

    task automatic run_random_beats(input int count, input bit pause_midway);
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                wait_for_results();
            random_beat();
        end
        wait_for_results();
    endtask

    task automatic test_reset_values();
        send_beat(1'b0, 32'h0000_0000, 1'b0);
        send_beat(1'b1, 32'h7FFF_FFFF, 1'b0);
        send_beat(1'b0, 32'h8000_0000, 1'b1);
        send_beat(1'b1, 32'h0000_0000, 1'b1);
        wait_for_results();
    endtask

    task automatic test_extreme_settings();
        cfg_t s;
        s = '{target_low: 32'h8000_0000, target_high: 32'h7FFF_FFFF, tolerance: '1,
              gain: '1, speed_min: '0, speed_max: 12'd3200, cycle_count: '1,
              dwell_ticks: '1};
        apply_settings(s);
        send_beat(1'b1, 32'h0000_0000, 1'b0);
        send_beat(1'b0, 32'h7FFF_FFFF, 1'b0);
        send_beat(1'b0, 32'h8000_0005, 1'b0);
        send_beat(1'b0, $urandom(), 1'b0);
        send_beat(1'b1, $urandom(), 1'b0);
        send_beat(1'b0, $urandom(), 1'b1);
        wait_for_results();
    endtask

    task automatic test_drive_shaping();
        cfg_t s;
        s = '{target_low: 32'd1000, target_high: -32'sd1000, tolerance: 20'd10,
              gain: 24'd65536, speed_min: 12'd200, speed_max: 12'd3000, cycle_count: 16'd1,
              dwell_ticks: '0};
        apply_settings(s);
        send_beat(1'b1, 32'd0, 1'b0);
        send_beat(1'b0, 32'd950, 1'b0);
        send_beat(1'b0, 32'd6000, 1'b0);
        send_beat(1'b0, 32'd991, 1'b0);
        send_beat(1'b0, -32'sd990, 1'b0);
        send_beat(1'b0, -32'sd1000, 1'b0);
        wait_for_results();
    endtask

    // speed_min above speed_max, and a zero tolerance that never lets the move end
    task automatic test_speed_limits();
        cfg_t s;
        s = '{target_low: '0, target_high: '0, tolerance: '0, gain: 24'd32768,
              speed_min: 12'd3200, speed_max: 12'd100, cycle_count: 16'd2, dwell_ticks: 16'd1};
        apply_settings(s);
        send_beat(1'b1, 32'd0, 1'b0);
        send_beat(1'b0, -32'sd100, 1'b0);
        send_beat(1'b0, 32'd1000, 1'b0);
        send_beat(1'b0, 32'd0, 1'b0);
        send_beat(1'b0, 32'd0, 1'b1);
        wait_for_results();
    endtask

    task automatic test_random_sequences();
        for (int round = 0; round < 4; round++)
        begin
            apply_settings(make_settings(1'b0));
            run_random_beats(150, round == 1);
        end
    endtask

    // Hold rsp off long enough for the pipeline to fill and req to stall
    task automatic test_backpressure();
        apply_settings(make_settings(1'b0));
        hold_cycles = 300;
        run_random_beats(60, 1'b0);
    endtask

    task automatic test_zero_tolerance();
        apply_settings(make_settings(1'b1));
        run_random_beats(50, 1'b0);
    endtask

    task automatic test_without_gaps();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        apply_settings(make_settings(1'b0));
        run_random_beats(150, 1'b0);
    endtask

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                rsp_if.ready <= 1'b1;
            end
            else if (sink_gaps && $urandom_range(0, 7) == 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                rsp_if.ready <= 1'b1;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            seen_status = '{rsp_if.speed_command, rsp_if.phase, rsp_if.sample_valid,
                            rsp_if.test_done};
            results_seen++;
            if (pending_status_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %0d: cmd %0d phase %0d", results_seen,
                             $signed(seen_status.speed_command), seen_status.phase);
            end
            else
            begin
                want_status = pending_status_q.pop_front();
                if (seen_status !== want_status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d: want cmd %0d phase %0d sample %0b done %0b",
                                 results_seen, $signed(want_status.speed_command),
                                 want_status.phase, want_status.sample_valid,
                                 want_status.test_done);
                        $display("result %0d: got  cmd %0d phase %0d sample %0b done %0b",
                                 results_seen, $signed(seen_status.speed_command),
                                 seen_status.phase, seen_status.sample_valid,
                                 seen_status.test_done);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_TARGET_LOW;
        cfg_data             = '0;
        req_if.valid         = 1'b0;
        req_if.operation     = 1'b0;
        req_if.encoder_count = '0;
        req_if.abort         = 1'b0;
        settings = '{target_low: '0, target_high: '0, tolerance: '0, gain: '0,
                     speed_min: SPEED_MIN_RST, speed_max: SPEED_MAX_RST, cycle_count: '0,
                     dwell_ticks: '0};
        seq_phase      = PH_IDLE;
        cycles_left    = '0;
        dwell_left     = '0;
        beats_sent     = 0;
        results_seen   = 0;
        mismatches     = 0;
        tests_ended    = 0;
        moves_done     = 0;
        drives_limited = 0;
        hold_cycles    = 0;
        src_gaps       = 1'b1;
        sink_gaps      = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_extreme_settings();
        test_drive_shaping();
        test_speed_limits();
        test_random_sequences();
        test_backpressure();
        test_zero_tolerance();
        test_without_gaps();

        repeat (10) @(posedge clk);
        $display("run covered %0d beats, %0d tests ended, %0d moves completed",
                 beats_sent, tests_ended, moves_done);
        $display("%0d drives clamped or raised, %0d results checked, %0d mismatches",
                 drives_limited, results_seen, mismatches);
        if (mismatches == 0 && pending_status_q.size() == 0)
            $display("PASS yoyo_position_controller_top");
        else
            $display("FAIL yoyo_position_controller_top");
        $finish;
    end

endmodule

// ===== yoyo_position_controller_top.f =====
+incdir+src
src/yoyo_pc_pkg.sv
src/yoyo_pc_in_if.sv
src/yoyo_pc_out_if.sv
src/yoyo_pc_ctrl.sv
src/yoyo_pc_drive.sv
src/yoyo_position_controller_top.sv
test/yoyo_position_controller_top_tb.sv
